// ----- hw/rtl/srsw_pkg.sv -----
package srsw_pkg;

    // Frame slots tracked by the acknowledge map
    localparam int FRAME_SLOTS = 256;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int HEAD_W      = $clog2(FRAME_SLOTS + 1);

    localparam int FRAME_W = 8;
    localparam int WIN_W   = 5;
    localparam int HEAD_OUT_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME  = 1'd1;

    // Opcodes
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_NAK  = 2'd2;

    // Reset values
    localparam logic [WIN_W-1:0]   WINDOW_SIZE_RST = 5'd5;
    localparam logic [FRAME_W-1:0] LAST_FRAME_RST  = 8'd1;
    localparam logic [HEAD_W-1:0]  HEAD_RST        = HEAD_W'(1);

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FRAME_W-1:0] frame_number;
    } t_in_item;

    typedef struct packed {
        logic                  send_valid;
        logic [FRAME_W-1:0]    send_frame;
        logic                  is_resend;
        logic [HEAD_OUT_W-1:0] window_head;
        logic                  all_acked;
    } t_out_item;

    // Acknowledge request into the map
    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] slot;
    } t_map_req;

    typedef struct packed {
        logic              busy;
        logic [HEAD_W-1:0] head;
    } t_map_stat;

endpackage

// ----- hw/rtl/srsw_ack_map.sv -----
module srsw_ack_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srsw_pkg::t_map_req  i_req,
    output srsw_pkg::t_map_stat o_stat
);
    import srsw_pkg::*;

    typedef enum logic [1:0] {
        M_CLEAR,
        M_IDLE,
        M_READ,
        M_CHECK
    } t_mstate;

    t_mstate             r_state;
    logic [SLOT_W-1:0]   r_clr_addr;
    logic [HEAD_W-1:0]   r_head;
    logic                r_rd_data;

    logic                mem [FRAME_SLOTS];

    logic                we;
    logic [SLOT_W-1:0]   waddr;
    logic                wdata;
    logic [SLOT_W-1:0]   raddr;
    logic                slot_ok;
    logic                head_in_range;

    assign slot_ok       = 9'(i_req.slot) < 9'(FRAME_SLOTS);
    assign head_in_range = r_head < HEAD_W'(FRAME_SLOTS);
    assign raddr         = r_head[SLOT_W-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = r_clr_addr;
        wdata = 1'b0;
        case (r_state)
            M_CLEAR: begin
                we = 1'b1;
            end
            M_IDLE: begin
                if (i_req.valid && slot_ok) begin
                    we    = 1'b1;
                    waddr = i_req.slot[SLOT_W-1:0];
                    wdata = 1'b1;
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= M_CLEAR;
            r_clr_addr <= '0;
            r_head     <= HEAD_RST;
        end else begin
            case (r_state)
                M_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == SLOT_W'(FRAME_SLOTS - 1)) begin
                        r_state <= M_IDLE;
                    end
                end
                M_IDLE: begin
                    if (i_req.valid && slot_ok) begin
                        r_state <= M_READ;
                    end
                end
                M_READ: begin
                    // stop at the end of the slot range
                    r_state <= head_in_range ? M_CHECK : M_IDLE;
                end
                M_CHECK: begin
                    if (r_rd_data) begin
                        r_head  <= r_head + 1'b1;
                        r_state <= M_READ;
                    end else begin
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    // A pending request counts as busy so the caller never sees a stale head
    assign o_stat.busy = (r_state != M_IDLE) || i_req.valid;
    assign o_stat.head = r_head;

endmodule

// ----- hw/rtl/selective_repeat_send_window_top.sv -----
// Channel | Direction | Handshake                     | Payload
// --------+-----------+-------------------------------+-----------------------------
// in      | in        | i_in_valid / o_in_ready       | i_in_data  (t_in_item)
// out     | out       | o_out_valid / i_out_ready     | o_out_data (t_out_item)
// cfg     | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A request is taken only in T_IDLE. Send, NAK and unused requests pass through T_EXEC and T_EMIT;
// T_EMIT loads the result once the output register is free. An ACK also waits in T_WAIT_MAP while
// the map moves the head over acked slots up to FRAME_SLOTS (read, then test the registered bit).
// After reset a clearing pass over all FRAME_SLOTS (256) slots empties the map; no
// request is taken meanwhile, configuration writes are.
// A stalled result stays in the output register while the next request is processed.
module selective_repeat_send_window_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  srsw_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output srsw_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import srsw_pkg::*;

    localparam int SUM_W = ((HEAD_W > WIN_W) ? HEAD_W : WIN_W) + 1;

    typedef enum logic [1:0] {
        T_IDLE,
        T_EXEC,
        T_WAIT_MAP,
        T_EMIT
    } t_state;

    t_state              r_state;
    logic [WIN_W-1:0]    r_window_size;
    logic [FRAME_W-1:0]  r_last_frame;
    logic [HEAD_W-1:0]   r_next_new;
    t_in_item            r_req;
    logic                r_send;
    logic [FRAME_W-1:0]  r_frame;
    logic                r_resend;
    t_map_req            r_map_req;
    logic                r_out_valid;
    t_out_item           r_out_data;

    t_map_stat           map_stat;
    logic                can_send;
    logic [SUM_W-1:0]    window_end;
    logic                out_free;

    srsw_ack_map u_ack_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_map_req),
        .o_stat  (map_stat)
    );

    assign window_end = SUM_W'(map_stat.head) + SUM_W'(r_window_size);
    assign can_send   = (SUM_W'(r_next_new) < window_end)
                     && (9'(r_next_new) <= 9'(r_last_frame))
                     && (r_next_new < HEAD_W'(FRAME_SLOTS));
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == T_IDLE) && !map_stat.busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= T_IDLE;
            r_window_size <= WINDOW_SIZE_RST;
            r_last_frame  <= LAST_FRAME_RST;
            r_next_new    <= HEAD_RST;
            r_map_req     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_map_req.valid <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WIN_W-1:0];
                    CFG_LAST_FRAME:  r_last_frame  <= i_cfg_data[FRAME_W-1:0];
                    default: begin
                        r_last_frame <= r_last_frame;
                    end
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                T_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_req   <= i_in_data;
                        r_state <= T_EXEC;
                    end
                end
                T_EXEC: begin
                    r_send   <= 1'b0;
                    r_frame  <= '0;
                    r_resend <= 1'b0;
                    r_state  <= T_EMIT;
                    case (r_req.opcode)
                        OP_SEND: begin
                            if (can_send) begin
                                r_send     <= 1'b1;
                                r_frame    <= FRAME_W'(r_next_new);
                                r_next_new <= r_next_new + 1'b1;
                            end
                        end
                        OP_ACK: begin
                            r_map_req.valid <= 1'b1;
                            r_map_req.slot  <= r_req.frame_number;
                            r_state         <= T_WAIT_MAP;
                        end
                        OP_NAK: begin
                            r_send   <= 1'b1;
                            r_frame  <= r_req.frame_number;
                            r_resend <= 1'b1;
                        end
                        default: begin
                            r_send <= 1'b0;
                        end
                    endcase
                end
                T_WAIT_MAP: begin
                    if (!map_stat.busy) begin
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_data.send_valid  <= r_send;
                        r_out_data.send_frame  <= r_frame;
                        r_out_data.is_resend   <= r_resend;
                        r_out_data.window_head <= HEAD_OUT_W'(map_stat.head);
                        r_out_data.all_acked   <= 9'(map_stat.head) > 9'(r_last_frame);
                        r_state                <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/srsw_checker.sv -----
module srsw_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  srsw_pkg::t_out_item                 o_out_data
);
    import srsw_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no send reported means empty frame fields
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.send_valid |->
            o_out_data.send_frame == '0 && !o_out_data.is_resend)
        else $error("frame fields set without a send");

    // the head never falls to frame 0
    a_head_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.window_head != '0)
        else $error("window head is zero");

    // map clearing follows reset, so no request is taken straight after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("request taken during clearing pass");

endmodule

bind selective_repeat_send_window_top srsw_checker u_srsw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
